>>> rtl/core/crv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crv_pkg
// Shared constants, codes and types of the congestion report validator.
// ----------------------------------------------------------------------------
package crv_pkg;

    // report bound and counter widths
    localparam int MAX_LINKS = 4096;
    localparam int COUNT_W   = 13;
    localparam logic [COUNT_W-1:0] COUNT_SAT = COUNT_W'(MAX_LINKS + 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_LINKS);

    // field widths
    localparam int CMD_W      = 2;
    localparam int GEN_W      = 64;
    localparam int WIN_W      = 32;
    localparam int ID_W       = 64;
    localparam int UTIL_W     = 16;
    localparam int RATE_W     = 16;
    localparam int LEVEL_W    = 3;
    localparam int THR_W      = 14;
    localparam int STATUS_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // limits
    localparam logic [UTIL_W-1:0] UTIL_LIMIT = 16'd10000;
    localparam logic [RATE_W-1:0] RATE_LIMIT = 16'd1000;

    // item kinds
    localparam logic [CMD_W-1:0] CMD_HEADER = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENTRY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_END    = 2'd2;

    // congestion levels
    localparam logic [LEVEL_W-1:0] LVL_UNKNOWN  = 3'd0;
    localparam logic [LEVEL_W-1:0] LVL_NONE     = 3'd1;
    localparam logic [LEVEL_W-1:0] LVL_LOW      = 3'd2;
    localparam logic [LEVEL_W-1:0] LVL_MODERATE = 3'd3;
    localparam logic [LEVEL_W-1:0] LVL_HIGH     = 3'd4;
    localparam logic [LEVEL_W-1:0] LVL_SEVERE   = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEVERE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODERATE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WINDOW = 3'd4;

    // configuration reset values
    localparam logic [THR_W-1:0] RST_SEVERE     = 14'd9500;
    localparam logic [THR_W-1:0] RST_HIGH       = 14'd8500;
    localparam logic [THR_W-1:0] RST_MODERATE   = 14'd7500;
    localparam logic [THR_W-1:0] RST_LOW        = 14'd6000;
    localparam logic [WIN_W-1:0] RST_MAX_WINDOW = 32'd3600000;

    // item queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // result queue
    localparam int RES_DEPTH = 2;
    localparam int RPTR_W    = 1;
    localparam int RCNT_W    = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 4'd0,
        ST_GEN_UNSET     = 4'd1,
        ST_TOPO_UNSET    = 4'd2,
        ST_WINDOW_ZERO   = 4'd3,
        ST_WINDOW_LONG   = 4'd4,
        ST_TOO_MANY      = 4'd5,
        ST_ID_UNSET      = 4'd6,
        ST_NOT_ASCENDING = 4'd7,
        ST_UTIL_OVER     = 4'd8,
        ST_COUNTERS_OVER = 4'd9,
        ST_LEVEL_UNKNOWN = 4'd10,
        ST_LEVEL_CONTRA  = 4'd11
    } t_status;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [GEN_W-1:0]   generation;
        logic [GEN_W-1:0]   topo_gen;
        logic [WIN_W-1:0]   window_ms;
        logic [ID_W-1:0]    link_id;
        logic [UTIL_W-1:0]  util_bp;
        logic [RATE_W-1:0]  ecn_rate;
        logic [RATE_W-1:0]  pfc_rate;
        logic [LEVEL_W-1:0] stated_level;
    } t_in_item;

    // classified item: header code or stateless entry code
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        t_status          code;
        logic [ID_W-1:0]  link_id;
    } t_item;

    typedef struct packed {
        t_status            status;
        logic [COUNT_W-1:0] error_index;
        logic [COUNT_W-1:0] entry_count;
    } t_result;

endpackage
`default_nettype wire

>>> rtl/core/crv_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crv_front
// Accepts items, holds the configuration registers and classifies each item
// with the checks that need no report state.
// ----------------------------------------------------------------------------
module crv_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_valid,
    input  wire [crv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [crv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                         o_cfg_ready,
    input  wire                          i_push,
    input  wire                          i_full,
    input  crv_pkg::t_in_item            i_in,
    output logic                         o_wr,
    output crv_pkg::t_item               o_item
);
    import crv_pkg::*;

    logic [THR_W-1:0]   r_severe;
    logic [THR_W-1:0]   r_high;
    logic [THR_W-1:0]   r_moderate;
    logic [THR_W-1:0]   r_low;
    logic [WIN_W-1:0]   r_max_window;
    logic [LEVEL_W-1:0] derived_level;
    t_status            hdr_code;
    t_status            entry_code;
    logic               accept;

    // configuration is always ready
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_severe     <= RST_SEVERE;
            r_high       <= RST_HIGH;
            r_moderate   <= RST_MODERATE;
            r_low        <= RST_LOW;
            r_max_window <= RST_MAX_WINDOW;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SEVERE:     r_severe     <= i_cfg_data[THR_W-1:0];
                CFG_HIGH:       r_high       <= i_cfg_data[THR_W-1:0];
                CFG_MODERATE:   r_moderate   <= i_cfg_data[THR_W-1:0];
                CFG_LOW:        r_low        <= i_cfg_data[THR_W-1:0];
                CFG_MAX_WINDOW: r_max_window <= i_cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // level from the threshold cascade, severe first
    always_comb begin
        priority if (i_in.util_bp >= {2'b00, r_severe})   derived_level = LVL_SEVERE;
        else if (i_in.util_bp >= {2'b00, r_high})         derived_level = LVL_HIGH;
        else if (i_in.util_bp >= {2'b00, r_moderate})     derived_level = LVL_MODERATE;
        else if (i_in.util_bp >= {2'b00, r_low})          derived_level = LVL_LOW;
        else                                              derived_level = LVL_NONE;
    end

    // header checks
    always_comb begin
        priority if (i_in.generation == '0)             hdr_code = ST_GEN_UNSET;
        else if (i_in.topo_gen == '0)                   hdr_code = ST_TOPO_UNSET;
        else if (i_in.window_ms == '0)                  hdr_code = ST_WINDOW_ZERO;
        else if (i_in.window_ms > r_max_window)         hdr_code = ST_WINDOW_LONG;
        else                                            hdr_code = ST_OK;
    end

    // entry checks that do not need the previous id
    always_comb begin
        priority if (i_in.link_id == '0)                entry_code = ST_ID_UNSET;
        else if (i_in.util_bp > UTIL_LIMIT)             entry_code = ST_UTIL_OVER;
        else if (i_in.ecn_rate > RATE_LIMIT ||
                 i_in.pfc_rate > RATE_LIMIT)            entry_code = ST_COUNTERS_OVER;
        else if (i_in.stated_level == LVL_UNKNOWN)      entry_code = ST_LEVEL_UNKNOWN;
        else if (i_in.stated_level != derived_level)    entry_code = ST_LEVEL_CONTRA;
        else                                            entry_code = ST_OK;
    end

    // queue write; unknown item kinds are taken and dropped
    assign accept = i_push && !i_full;

    always_comb begin
        o_item.cmd     = i_in.cmd;
        o_item.link_id = i_in.link_id;
        o_item.code    = ST_OK;
        o_wr           = 1'b0;
        unique case (i_in.cmd)
            CMD_HEADER: begin
                o_item.code = hdr_code;
                o_wr        = accept;
            end
            CMD_ENTRY: begin
                o_item.code = entry_code;
                o_wr        = accept;
            end
            CMD_END: begin
                o_wr = accept;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/core/crv_item_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crv_item_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module crv_item_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_wr,
    input  crv_pkg::t_item  i_item,
    output logic            o_full,
    input  wire             i_rd,
    output crv_pkg::t_item  o_item,
    output logic            o_empty
);
    import crv_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wptr;
    logic [QPTR_W-1:0] n_rptr;
    logic [QCNT_W-1:0] n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rptr];

    // pointer and fill update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_wr) begin
            n_wptr = r_wptr + 1'b1;
        end
        if (i_rd) begin
            n_rptr = r_rptr + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr && i_rd) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/crv_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crv_back
// Keeps the report state, checks id order, captures the first entry error
// and queues one status result for each end of report.
// ----------------------------------------------------------------------------
module crv_back (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  crv_pkg::t_item              i_item,
    input  wire                         i_empty,
    output logic                        o_rd,
    input  wire                         i_pop,
    output logic                        o_empty,
    output crv_pkg::t_result            o_result
);
    import crv_pkg::*;

    t_status             r_hdr_err;
    t_status             r_entry_err;
    logic [COUNT_W-1:0]  r_first_idx;
    logic [COUNT_W-1:0]  r_seen;
    logic [ID_W-1:0]     r_prev_link;
    logic                r_have_prev;
    t_status             n_hdr_err;
    t_status             n_entry_err;
    logic [COUNT_W-1:0]  n_first_idx;
    logic [COUNT_W-1:0]  n_seen;
    logic [ID_W-1:0]     n_prev_link;
    logic                n_have_prev;

    t_result             r_res_mem [RES_DEPTH];
    logic [RPTR_W-1:0]   r_res_wptr;
    logic [RPTR_W-1:0]   r_res_rptr;
    logic [RCNT_W-1:0]   r_res_count;

    t_status             entry_code;
    t_result             result;
    logic                res_full;
    logic                res_push;
    logic                res_pop;

    assign res_full = (r_res_count == RCNT_W'(RES_DEPTH));
    assign res_pop  = i_pop && (r_res_count != '0);
    assign o_empty  = (r_res_count == '0);
    assign o_result = r_res_mem[r_res_rptr];

    // take an item unless it is an end item and the result queue is full
    assign o_rd     = !i_empty && ((i_item.cmd != CMD_END) || !res_full);
    assign res_push = o_rd && (i_item.cmd == CMD_END);

    // id order check, slotted into the entry error priority
    always_comb begin
        priority if (i_item.code == ST_ID_UNSET)                  entry_code = ST_ID_UNSET;
        else if (r_have_prev && !(r_prev_link < i_item.link_id))  entry_code = ST_NOT_ASCENDING;
        else                                                      entry_code = i_item.code;
    end

    // status of the report so far
    always_comb begin
        result.entry_count = r_seen;
        result.error_index = '0;
        priority if (r_hdr_err != ST_OK) begin
            result.status = r_hdr_err;
        end else if (r_seen > COUNT_MAX) begin
            result.status = ST_TOO_MANY;
        end else if (r_entry_err != ST_OK) begin
            result.status      = r_entry_err;
            result.error_index = r_first_idx;
        end else begin
            result.status = ST_OK;
        end
    end

    // report state update
    always_comb begin
        n_hdr_err   = r_hdr_err;
        n_entry_err = r_entry_err;
        n_first_idx = r_first_idx;
        n_seen      = r_seen;
        n_prev_link = r_prev_link;
        n_have_prev = r_have_prev;
        if (o_rd) begin
            unique case (i_item.cmd)
                CMD_HEADER: begin
                    n_hdr_err   = i_item.code;
                    n_entry_err = ST_OK;
                    n_first_idx = '0;
                    n_seen      = '0;
                    n_prev_link = '0;
                    n_have_prev = 1'b0;
                end
                CMD_ENTRY: begin
                    if (r_entry_err == ST_OK && entry_code != ST_OK) begin
                        n_entry_err = entry_code;
                        n_first_idx = r_seen;
                    end
                    n_prev_link = i_item.link_id;
                    n_have_prev = 1'b1;
                    if (r_seen < COUNT_SAT) begin
                        n_seen = r_seen + 1'b1;
                    end
                end
                CMD_END: begin
                    n_hdr_err   = ST_OK;
                    n_entry_err = ST_OK;
                    n_first_idx = '0;
                    n_seen      = '0;
                    n_prev_link = '0;
                    n_have_prev = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_err   <= ST_OK;
            r_entry_err <= ST_OK;
            r_first_idx <= '0;
            r_seen      <= '0;
            r_prev_link <= '0;
            r_have_prev <= 1'b0;
        end else begin
            r_hdr_err   <= n_hdr_err;
            r_entry_err <= n_entry_err;
            r_first_idx <= n_first_idx;
            r_seen      <= n_seen;
            r_prev_link <= n_prev_link;
            r_have_prev <= n_have_prev;
        end
    end

    // result queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_wptr  <= '0;
            r_res_rptr  <= '0;
            r_res_count <= '0;
        end else begin
            if (res_push) begin
                r_res_wptr <= r_res_wptr + 1'b1;
            end
            if (res_pop) begin
                r_res_rptr <= r_res_rptr + 1'b1;
            end
            if (res_push && !res_pop) begin
                r_res_count <= r_res_count + 1'b1;
            end else if (!res_push && res_pop) begin
                r_res_count <= r_res_count - 1'b1;
            end
        end
    end

    // result storage
    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_res_mem[r_res_wptr] <= result;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/congestion_report_validator.sv
// Path: an end item enters the item queue on its transfer; the back takes it from
// there and writes its status into the result queue. Throughput: one item per
// cycle while full is low; the four-entry item and two-entry result queues let
// input and output stall on their own; full rises once four items wait.
// Reset: synchronous, active low; empties both queues, clears the report state and
// loads the threshold and window registers with their default values.
`default_nettype none
// ----------------------------------------------------------------------------
// congestion_report_validator
// Validates congestion reports (header, link entries, end) and returns one
// status per report.
// ----------------------------------------------------------------------------
module congestion_report_validator (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // configuration write channel
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [crv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [crv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // item input
    input  wire                          push,
    output logic                         full,
    input  wire [crv_pkg::CMD_W-1:0]      i_cmd,
    input  wire [crv_pkg::GEN_W-1:0]      i_generation,
    input  wire [crv_pkg::GEN_W-1:0]      i_topo_gen,
    input  wire [crv_pkg::WIN_W-1:0]      i_window_ms,
    input  wire [crv_pkg::ID_W-1:0]       i_link_id,
    input  wire [crv_pkg::UTIL_W-1:0]     i_util_bp,
    input  wire [crv_pkg::RATE_W-1:0]     i_ecn_rate,
    input  wire [crv_pkg::RATE_W-1:0]     i_pfc_rate,
    input  wire [crv_pkg::LEVEL_W-1:0]    i_stated_level,
    // result output
    output logic                         empty,
    input  wire                          pop,
    output logic [crv_pkg::STATUS_W-1:0] o_status_code,
    output logic [crv_pkg::COUNT_W-1:0]  o_error_index,
    output logic [crv_pkg::COUNT_W-1:0]  o_entry_count
);
    import crv_pkg::*;

    t_in_item in_item;
    t_item    wr_item;
    t_item    rd_item;
    t_result  result;
    logic     q_wr;
    logic     q_rd;
    logic     q_full;
    logic     q_empty;

    // pack input fields
    always_comb begin
        in_item.cmd          = i_cmd;
        in_item.generation   = i_generation;
        in_item.topo_gen     = i_topo_gen;
        in_item.window_ms    = i_window_ms;
        in_item.link_id      = i_link_id;
        in_item.util_bp      = i_util_bp;
        in_item.ecn_rate     = i_ecn_rate;
        in_item.pfc_rate     = i_pfc_rate;
        in_item.stated_level = i_stated_level;
    end

    assign full = q_full;

    // front: accept and classify
    crv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_push      (push),
        .i_full      (q_full),
        .i_in        (in_item),
        .o_wr        (q_wr),
        .o_item      (wr_item)
    );

    // queue between front and back
    crv_item_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_item  (wr_item),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_item  (rd_item),
        .o_empty (q_empty)
    );

    // back: report state and results
    crv_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (rd_item),
        .i_empty  (q_empty),
        .o_rd     (q_rd),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_result (result)
    );

    assign o_status_code = result.status;
    assign o_error_index = result.error_index;
    assign o_entry_count = result.entry_count;

endmodule
`default_nettype wire

>>> rtl/core/crv_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crv_checker
// Port-level checks of the congestion report validator, bound to the top.
// ----------------------------------------------------------------------------
module crv_checker (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          empty,
    input  wire [crv_pkg::STATUS_W-1:0]  o_status_code,
    input  wire [crv_pkg::COUNT_W-1:0]   o_error_index,
    input  wire [crv_pkg::COUNT_W-1:0]   o_entry_count
);
    import crv_pkg::*;

    // reset leaves no result waiting
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result waiting after reset");

    // status stays within the defined codes
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_status_code <= STATUS_W'(ST_LEVEL_CONTRA))
        else $error("status code out of range");

    // error index only for entry errors
    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status_code < STATUS_W'(ST_ID_UNSET)) |-> o_error_index == '0)
        else $error("error index set without an entry error");

    // an entry error points inside the report
    a_index_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status_code >= STATUS_W'(ST_ID_UNSET)) |-> o_error_index < o_entry_count)
        else $error("error index beyond entry count");

    // too many entries only with a saturated count
    a_too_many: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status_code == STATUS_W'(ST_TOO_MANY)) |-> o_entry_count == COUNT_SAT)
        else $error("too many reported without saturated count");

endmodule

bind congestion_report_validator crv_checker u_checker (.*);
`default_nettype wire

>>> tb/congestion_report_validator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// congestion_report_validator_tb
// Sends congestion reports (header, link entries, end) into the validator,
// keeps its own running copy of the report checks and compares every popped
// status with the status it expects. Runs directed cases, four random phases
// under different threshold settings and idling, and a long receiver
// hold-off that fills the block.
// ----------------------------------------------------------------------------
module congestion_report_validator_tb;
    import crv_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int RESET_CYC   = 8;
    localparam int DRAIN_WAIT  = 12;
    localparam int CYCLE_LIMIT = 250000;
    localparam int PHASE_ITEMS = 160;
    localparam int HOLD_CYC    = 400;

    // item kind that the block ignores, and a level beyond the defined ones
    localparam logic [CMD_W-1:0]   CMD_SPARE  = 2'd3;
    localparam logic [LEVEL_W-1:0] LVL_BEYOND = 3'd7;

    // block ports
    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = CFG_SEVERE;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  push           = 1'b0;
    logic                  full;
    logic [CMD_W-1:0]      i_cmd          = CMD_SPARE;
    logic [GEN_W-1:0]      i_generation   = '0;
    logic [GEN_W-1:0]      i_topo_gen     = '0;
    logic [WIN_W-1:0]      i_window_ms    = '0;
    logic [ID_W-1:0]       i_link_id      = '0;
    logic [UTIL_W-1:0]     i_util_bp      = '0;
    logic [RATE_W-1:0]     i_ecn_rate     = '0;
    logic [RATE_W-1:0]     i_pfc_rate     = '0;
    logic [LEVEL_W-1:0]    i_stated_level = LVL_UNKNOWN;
    logic                  empty;
    logic                  pop            = 1'b0;
    logic [STATUS_W-1:0]   o_status_code;
    logic [COUNT_W-1:0]    o_error_index;
    logic [COUNT_W-1:0]    o_entry_count;

    // running copy of the block's registers and report state
    logic [THR_W-1:0]   level_thr [4];
    logic [WIN_W-1:0]   window_limit;
    t_status            hdr_fault;
    t_status            first_fault;
    logic [COUNT_W-1:0] first_fault_idx;
    logic [COUNT_W-1:0] links_seen;
    logic [ID_W-1:0]    last_link;
    logic               seen_link;
    t_result            report_status_q [$];

    // run control
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int recv_hold      = 0;
    int items_sent     = 0;
    int fail_count     = 0;
    int cycle_count    = 0;

    congestion_report_validator DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_cmd          (i_cmd),
        .i_generation   (i_generation),
        .i_topo_gen     (i_topo_gen),
        .i_window_ms    (i_window_ms),
        .i_link_id      (i_link_id),
        .i_util_bp      (i_util_bp),
        .i_ecn_rate     (i_ecn_rate),
        .i_pfc_rate     (i_pfc_rate),
        .i_stated_level (i_stated_level),
        .empty          (empty),
        .pop            (pop),
        .o_status_code  (o_status_code),
        .o_error_index  (o_error_index),
        .o_entry_count  (o_entry_count)
    );

    // clock
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // report tracking
    // ------------------------------------------------------------------------

    function automatic void clear_report();
        hdr_fault       = ST_OK;
        first_fault     = ST_OK;
        first_fault_idx = '0;
        links_seen      = '0;
        last_link       = '0;
        seen_link       = 1'b0;
    endfunction

    // threshold cascade, severe tested first whatever the register order
    function automatic logic [LEVEL_W-1:0] level_for_util(input logic [UTIL_W-1:0] util);
        if (util >= level_thr[CFG_SEVERE]) return LVL_SEVERE;
        if (util >= level_thr[CFG_HIGH]) return LVL_HIGH;
        if (util >= level_thr[CFG_MODERATE]) return LVL_MODERATE;
        if (util >= level_thr[CFG_LOW]) return LVL_LOW;
        return LVL_NONE;
    endfunction

    function automatic t_status entry_fault(input t_in_item it);
        if (it.link_id == '0) return ST_ID_UNSET;
        if (seen_link && !(last_link < it.link_id)) return ST_NOT_ASCENDING;
        if (it.util_bp > UTIL_LIMIT) return ST_UTIL_OVER;
        if (it.ecn_rate > RATE_LIMIT || it.pfc_rate > RATE_LIMIT)
            return ST_COUNTERS_OVER;
        if (it.stated_level == LVL_UNKNOWN) return ST_LEVEL_UNKNOWN;
        if (it.stated_level != level_for_util(it.util_bp)) return ST_LEVEL_CONTRA;
        return ST_OK;
    endfunction

    // update the report state with one accepted item, queue a status on end
    function automatic void advance_report(input t_in_item it);
        t_status code;
        t_result res;
        case (it.cmd)
            CMD_HEADER: begin
                clear_report();
                if (it.generation == '0) hdr_fault = ST_GEN_UNSET;
                else if (it.topo_gen == '0) hdr_fault = ST_TOPO_UNSET;
                else if (it.window_ms == '0) hdr_fault = ST_WINDOW_ZERO;
                else if (it.window_ms > window_limit) hdr_fault = ST_WINDOW_LONG;
            end
            CMD_ENTRY: begin
                code = entry_fault(it);
                if (first_fault == ST_OK && code != ST_OK) begin
                    first_fault     = code;
                    first_fault_idx = links_seen;
                end
                last_link = it.link_id;
                seen_link = 1'b1;
                if (links_seen < COUNT_SAT) links_seen++;
            end
            CMD_END: begin
                res.status      = ST_OK;
                res.error_index = '0;
                res.entry_count = links_seen;
                if (hdr_fault != ST_OK) begin
                    res.status = hdr_fault;
                end else if (links_seen > COUNT_MAX) begin
                    res.status = ST_TOO_MANY;
                end else if (first_fault != ST_OK) begin
                    res.status      = first_fault;
                    res.error_index = first_fault_idx;
                end
                report_status_q.push_back(res);
                clear_report();
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // item makers
    // ------------------------------------------------------------------------

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_nonzero64();
        logic [63:0] v;
        do begin
            v = rand64() >> $urandom_range(0, 63);
        end while (v == '0);
        return v;
    endfunction

    // fields that the item kind does not use carry random values
    function automatic t_in_item make_item(input logic [CMD_W-1:0] cmd);
        t_in_item it;
        it.cmd          = cmd;
        it.generation   = rand64();
        it.topo_gen     = rand64();
        it.window_ms    = $urandom;
        it.link_id      = rand64();
        it.util_bp      = UTIL_W'($urandom);
        it.ecn_rate     = RATE_W'($urandom);
        it.pfc_rate     = RATE_W'($urandom);
        it.stated_level = LEVEL_W'($urandom);
        return it;
    endfunction

    function automatic t_in_item good_header();
        t_in_item it;
        it            = make_item(CMD_HEADER);
        it.generation = rand_nonzero64();
        it.topo_gen   = rand_nonzero64();
        it.window_ms  = $urandom_range(1, window_limit);
        return it;
    endfunction

    function automatic t_in_item good_entry(input logic [ID_W-1:0] link);
        t_in_item it;
        it              = make_item(CMD_ENTRY);
        it.link_id      = link;
        it.util_bp      = UTIL_W'($urandom_range(0, UTIL_LIMIT));
        it.ecn_rate     = RATE_W'($urandom_range(0, RATE_LIMIT));
        it.pfc_rate     = RATE_W'($urandom_range(0, RATE_LIMIT));
        it.stated_level = level_for_util(it.util_bp);
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // one item transfer, with random idle cycles in front
    task automatic send_item(input t_in_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push           <= 1'b1;
        i_cmd          <= it.cmd;
        i_generation   <= it.generation;
        i_topo_gen     <= it.topo_gen;
        i_window_ms    <= it.window_ms;
        i_link_id      <= it.link_id;
        i_util_bp      <= it.util_bp;
        i_ecn_rate     <= it.ecn_rate;
        i_pfc_rate     <= it.pfc_rate;
        i_stated_level <= it.stated_level;
        do @(posedge i_clk); while (full);
        advance_report(it);
        if (it.cmd != CMD_SPARE) items_sent++;
    endtask

    task automatic close_report();
        send_item(make_item(CMD_END));
    endtask

    // stop sending until every status is back and the pipeline has emptied
    task automatic wait_reports_done();
        @(negedge i_clk);
        push <= 1'b0;
        while (report_status_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MAX_WINDOW: window_limit = value;
            default: level_thr[idx] = value[THR_W-1:0];
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] severe,
                              input logic [CFG_DATA_W-1:0] high,
                              input logic [CFG_DATA_W-1:0] moderate,
                              input logic [CFG_DATA_W-1:0] low,
                              input logic [CFG_DATA_W-1:0] win);
        wait_reports_done();
        write_reg(CFG_SEVERE, severe);
        write_reg(CFG_HIGH, high);
        write_reg(CFG_MODERATE, moderate);
        write_reg(CFG_LOW, low);
        write_reg(CFG_MAX_WINDOW, win);
    endtask

    // mostly well-formed report with random content, some broken
    task automatic send_random_report();
        t_in_item        it;
        logic [ID_W-1:0] link;
        logic [ID_W-1:0] prev;
        int              links;
        links = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        // header, sometimes broken, now and then left out
        if ($urandom_range(0, 99) >= 4) begin
            it = good_header();
            if ($urandom_range(0, 99) < 12) begin
                case ($urandom_range(0, 3))
                    0: it.generation = '0;
                    1: it.topo_gen = '0;
                    2: it.window_ms = '0;
                    default: it.window_ms = (window_limit == '1) ? '0 :
                        $urandom_range(window_limit + 1, 32'hFFFF_FFFF);
                endcase
            end
            send_item(it);
        end
        // ascending ids with random step sizes
        link = rand64() >> $urandom_range(1, 63);
        repeat (links) begin
            prev = link;
            link = link + (rand64() >> $urandom_range(6, 63)) + 64'd1;
            it   = good_entry(link);
            if ($urandom_range(0, 99) < 6) begin
                case ($urandom_range(0, 6))
                    0: it.link_id = '0;
                    1: it.link_id = prev - 64'($urandom_range(0, 2));
                    2: it.util_bp = UTIL_W'($urandom_range(UTIL_LIMIT + 1, 16'hFFFF));
                    3: it.ecn_rate = RATE_W'($urandom_range(RATE_LIMIT + 1, 16'hFFFF));
                    4: it.pfc_rate = RATE_W'($urandom_range(RATE_LIMIT + 1, 16'hFFFF));
                    5: it.stated_level = LVL_UNKNOWN;
                    default: it.stated_level = level_for_util(it.util_bp)
                                               + LEVEL_W'($urandom_range(1, 6));
                endcase
            end
            send_item(it);
            link = it.link_id;
        end
        if ($urandom_range(0, 99) < 3) send_item(make_item(CMD_SPARE));
        // a missing end lets the next report run on from this one if it has no header
        if ($urandom_range(0, 99) >= 3) close_report();
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct);
        int target;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        target         = items_sent + PHASE_ITEMS;
        while (items_sent < target) send_random_report();
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // each entry fault on its own, entries with no header in front
    task automatic test_entry_checks();
        t_in_item it;
        send_item(good_entry('0));
        close_report();
        // repeated id, then a later fault that must not replace the first
        send_item(good_entry(64'd5));
        send_item(good_entry(64'd5));
        it = good_entry(64'd9);
        it.util_bp = '1;
        send_item(it);
        close_report();
        it = good_entry(64'd3);
        it.util_bp = '1;
        send_item(it);
        close_report();
        it = good_entry(64'd3);
        it.ecn_rate = RATE_LIMIT + 16'd1;
        send_item(it);
        close_report();
        it = good_entry(64'd3);
        it.pfc_rate = '1;
        send_item(it);
        close_report();
        it = good_entry(64'd3);
        it.stated_level = LVL_UNKNOWN;
        send_item(it);
        close_report();
        it = good_entry(64'd3);
        it.stated_level = LVL_BEYOND;
        send_item(it);
        close_report();
    endtask

    task automatic test_header_checks();
        t_in_item it;
        it = good_header();
        it.generation = '0;
        send_item(it);
        close_report();
        it = good_header();
        it.topo_gen = '0;
        send_item(it);
        close_report();
        it = good_header();
        it.window_ms = '0;
        send_item(it);
        close_report();
        it = good_header();
        it.window_ms = window_limit + 32'd1;
        send_item(it);
        close_report();
    endtask

    // valid report with field extremes and an ignored item inside
    task automatic test_clean_report();
        t_in_item it;
        it = good_header();
        it.generation = '1;
        it.topo_gen   = '1;
        it.window_ms  = window_limit;
        send_item(it);
        it = good_entry(64'd1);
        it.util_bp      = '0;
        it.ecn_rate     = '0;
        it.pfc_rate     = '0;
        it.stated_level = level_for_util('0);
        send_item(it);
        it = good_entry('1);
        it.util_bp      = UTIL_LIMIT;
        it.ecn_rate     = RATE_LIMIT;
        it.pfc_rate     = RATE_LIMIT;
        it.stated_level = level_for_util(UTIL_LIMIT);
        send_item(it);
        send_item(make_item(CMD_SPARE));
        close_report();
    endtask

    task automatic test_default_thresholds();
        run_phase(0, 0);
    endtask

    task automatic test_wide_window();
        set_config(32'd10000, 32'd9000, 32'd5000, 32'd0, 32'hFFFF_FFFF);
        run_phase(57, 0);
    endtask

    task automatic test_zero_thresholds();
        set_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd1);
        run_phase(0, 57);
    endtask

    task automatic test_crossed_thresholds();
        set_config(32'd2000, 32'd8000, 32'd3000, 32'd9000, 32'd1000);
        run_phase(10, 10);
    endtask

    // receiver holds off while short reports keep coming, so the block fills
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 20;
        recv_hold      = HOLD_CYC;
        repeat (40) begin
            send_item(good_header());
            close_report();
        end
        wait_reports_done();
        repeat (10) send_random_report();
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------

    // pop driver: long hold-off first when asked, otherwise random stalls
    initial begin
        forever begin
            @(negedge i_clk);
            if (recv_hold > 0) begin
                pop <= 1'b0;
                recv_hold--;
            end else begin
                pop <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // compare each status transfer with the oldest pending status
    initial begin
        t_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                if (report_status_q.size() == 0) begin
                    $display("%0t: unexpected status transfer, expected none, actual %0d",
                             $time, o_status_code);
                    fail_count++;
                end else begin
                    want = report_status_q.pop_front();
                    if (o_status_code !== want.status) begin
                        $display("%0t: status_code expected %0d actual %0d",
                                 $time, want.status, o_status_code);
                        fail_count++;
                    end
                    if (o_error_index !== want.error_index) begin
                        $display("%0t: error_index expected %0d actual %0d",
                                 $time, want.error_index, o_error_index);
                        fail_count++;
                    end
                    if (o_entry_count !== want.entry_count) begin
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, want.entry_count, o_entry_count);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("congestion_report_validator_tb failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial begin
        level_thr[CFG_SEVERE]   = RST_SEVERE;
        level_thr[CFG_HIGH]     = RST_HIGH;
        level_thr[CFG_MODERATE] = RST_MODERATE;
        level_thr[CFG_LOW]      = RST_LOW;
        window_limit            = RST_MAX_WINDOW;
        clear_report();
        repeat (RESET_CYC) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_entry_checks();
        test_header_checks();
        test_clean_report();
        test_default_thresholds();
        test_wide_window();
        test_zero_thresholds();
        test_crossed_thresholds();
        test_backpressure();

        // let every status come back before judging
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_reports_done();
        if (fail_count == 0) begin
            $display("congestion_report_validator_tb passed");
        end else begin
            $display("congestion_report_validator_tb failed");
        end
        $finish;
    end

endmodule
